// ----- rtl/dtx_pkg.sv -----
// shared types and character codes for the tab expander
package dtx_pkg;

   // width of the column and tab countdown counters
   localparam int COL_W = 6;

   // character codes
   localparam logic [7:0] CH_BS  = 8'd8;
   localparam logic [7:0] CH_TAB = 8'd9;
   localparam logic [7:0] CH_NL  = 8'd10;
   localparam logic [7:0] CH_VT  = 8'd11;
   localparam logic [7:0] CH_SP  = 8'd32;
   localparam logic [7:0] CH_DEL = 8'd127;

   // tab size after reset
   localparam logic [COL_W-1:0] STOP_GAP_RESET = 6'd8;

   // command queue depth and pointer width
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   // one output run: optional head char, a run of spaces, optional trailing backspace
   typedef struct packed {
      logic             has_head;
      logic [7:0]       head;
      logic [COL_W-1:0] spaces;
      logic             has_tail;
   } cmd_type;

   // output sequencer phase
   typedef enum logic [2:0] {
      PH_START = 3'b001,
      PH_SPACE = 3'b010,
      PH_TAIL  = 3'b100
   } phase_type;

endpackage

// ----- rtl/dtx_front.sv -----
// front end: accepts requests, tracks column and tab stop, builds output commands
module dtx_front #(
   parameter int MAX_COLUMN = 63
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [dtx_pkg::COL_W-1:0] csr_wdata,
   input  logic                    accept,
   input  logic [7:0]              in_char,
   input  logic                    end_of_input,
   output dtx_pkg::cmd_type        cmd
);

   localparam logic [dtx_pkg::COL_W-1:0] MaxCol = dtx_pkg::COL_W'(MAX_COLUMN);

   logic [dtx_pkg::COL_W-1:0] size_ff, size_in;
   logic [dtx_pkg::COL_W-1:0] cd_ff, cd_in;
   logic [dtx_pkg::COL_W-1:0] col_ff, col_in;
   logic [dtx_pkg::COL_W-1:0] eff_size;
   logic [dtx_pkg::COL_W-1:0] tab_run;
   logic [dtx_pkg::COL_W-1:0] col_add;
   logic [dtx_pkg::COL_W:0]   col_sum;
   logic [dtx_pkg::COL_W-1:0] col_sat;

   // a zero tab size behaves as one
   assign eff_size = (size_ff == '0) ? dtx_pkg::COL_W'(1) : size_ff;
   assign tab_run  = (cd_ff == '0) ? eff_size : cd_ff;

   // saturating column advance
   assign col_add = (in_char == dtx_pkg::CH_TAB) ? tab_run : dtx_pkg::COL_W'(1);
   assign col_sum = {1'b0, col_ff} + {1'b0, col_add};
   assign col_sat = (col_sum > {1'b0, MaxCol}) ? MaxCol : col_sum[dtx_pkg::COL_W-1:0];

   // classify the request
   always_comb begin
      size_in      = csr_we ? csr_wdata : size_ff;
      cd_in        = cd_ff;
      col_in       = col_ff;
      cmd.has_head = 1'b1;
      cmd.head     = in_char;
      cmd.spaces   = '0;
      cmd.has_tail = 1'b0;
      if (end_of_input || in_char == dtx_pkg::CH_NL) begin
         cmd.head = dtx_pkg::CH_NL;
         col_in   = '0;
         cd_in    = eff_size;
      end else if (in_char == dtx_pkg::CH_TAB) begin
         cmd.has_head = 1'b0;
         cmd.spaces   = tab_run;
         col_in       = col_sat;
         cd_in        = eff_size;
      end else if (in_char == dtx_pkg::CH_VT) begin
         cmd.head   = dtx_pkg::CH_NL;
         cmd.spaces = col_ff;
         cd_in      = eff_size;
      end else if (in_char == dtx_pkg::CH_DEL) begin
         cmd.head     = dtx_pkg::CH_BS;
         cmd.spaces   = dtx_pkg::COL_W'(1);
         cmd.has_tail = 1'b1;
         col_in       = (col_ff == '0) ? '0 : col_ff - dtx_pkg::COL_W'(1);
         cd_in        = (cd_ff >= eff_size) ? dtx_pkg::COL_W'(1)
                                            : cd_ff + dtx_pkg::COL_W'(1);
      end else begin
         col_in = col_sat;
         cd_in  = (cd_ff <= dtx_pkg::COL_W'(1)) ? eff_size : cd_ff - dtx_pkg::COL_W'(1);
      end
   end

   // counter and register state
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= dtx_pkg::STOP_GAP_RESET;
         cd_ff   <= dtx_pkg::STOP_GAP_RESET;
         col_ff  <= '0;
      end else begin
         size_ff <= size_in;
         if (accept) begin
            cd_ff  <= cd_in;
            col_ff <= col_in;
         end
      end
   end

endmodule

// ----- rtl/dtx_queue.sv -----
// short command queue between front end and output sequencer
module dtx_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  dtx_pkg::cmd_type push_cmd,
   input  logic             pop,
   output dtx_pkg::cmd_type head_cmd,
   output logic             not_empty,
   output logic             full
);

   dtx_pkg::cmd_type              slot_ff [dtx_pkg::QUEUE_DEPTH];
   logic [dtx_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [dtx_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [dtx_pkg::QPTR_W:0]      count_ff, count_in;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == (dtx_pkg::QPTR_W+1)'(dtx_pkg::QUEUE_DEPTH));
   assign head_cmd  = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- rtl/dtx_back.sv -----
// output sequencer: expands queued commands into one character per cycle while the output is not stalled
module dtx_back (
   input  logic             clock,
   input  logic             reset,
   input  dtx_pkg::cmd_type head_cmd,
   input  logic             not_empty,
   output logic             pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tlast
);

   dtx_pkg::phase_type        phase_ff, phase_in;
   logic [dtx_pkg::COL_W-1:0] cnt_ff, cnt_in;
   logic                      out_valid_ff, out_valid_in;
   logic [7:0]                out_char_ff, out_char_in;
   logic                      out_last_ff, out_last_in;
   logic                      advance;
   logic [7:0]                emit_char;
   logic [dtx_pkg::COL_W-1:0] spaces_done;
   logic                      at_tail;

   assign advance    = !out_valid_ff || rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_char_ff;
   assign rsp_tlast  = out_last_ff;

   // character for the current phase
   always_comb begin
      emit_char   = dtx_pkg::CH_SP;
      spaces_done = cnt_ff;
      at_tail     = 1'b0;
      case (phase_ff)
         dtx_pkg::PH_START: begin
            if (head_cmd.has_head) begin
               emit_char   = head_cmd.head;
               spaces_done = '0;
            end else begin
               spaces_done = dtx_pkg::COL_W'(1);
            end
         end
         dtx_pkg::PH_SPACE: begin
            spaces_done = cnt_ff + dtx_pkg::COL_W'(1);
         end
         dtx_pkg::PH_TAIL: begin
            emit_char = dtx_pkg::CH_BS;
            at_tail   = 1'b1;
         end
         default: begin
            at_tail = 1'b1;
         end
      endcase
   end

   // next phase and output register load
   always_comb begin
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      pop          = 1'b0;
      if (advance) begin
         out_valid_in = not_empty;
         out_char_in  = emit_char;
         out_last_in  = 1'b0;
         if (not_empty) begin
            if (!at_tail && spaces_done < head_cmd.spaces) begin
               phase_in = dtx_pkg::PH_SPACE;
               cnt_in   = spaces_done;
            end else if (!at_tail && head_cmd.has_tail) begin
               phase_in = dtx_pkg::PH_TAIL;
            end else begin
               phase_in    = dtx_pkg::PH_START;
               cnt_in      = '0;
               out_last_in = 1'b1;
               pop         = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= dtx_pkg::PH_START;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

endmodule

// ----- rtl/detab_tab_expander_core.sv -----
// top level of the tab expander: front end, command queue, output sequencer
// rsp_tvalid rises once an accepted request has passed through the command queue and the output register
// throughput: one result character per cycle while the result side is ready; a request
//   produces 1 result character, 3 for delete, up to 64
// the four-entry command queue lets requests run ahead of long space runs
// reset: synchronous, active high; tab size and tab countdown return to 8, column to 0
module detab_tab_expander_core #(
   parameter int MAX_COLUMN = 63
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_char
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic       rsp_tlast,
   input  logic       csr_we,
   input  logic [5:0] csr_wdata
);

   dtx_pkg::cmd_type front_cmd;
   dtx_pkg::cmd_type head_cmd;
   logic             accept;
   logic             q_full;
   logic             q_not_empty;
   logic             q_pop;

   // request acceptance while the queue has room
   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   dtx_front #(
      .MAX_COLUMN (MAX_COLUMN)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .accept       (accept),
      .in_char      (req_tdata),
      .end_of_input (req_tlast),
      .cmd          (front_cmd)
   );

   dtx_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_cmd  (front_cmd),
      .pop       (q_pop),
      .head_cmd  (head_cmd),
      .not_empty (q_not_empty),
      .full      (q_full)
   );

   dtx_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_cmd   (head_cmd),
      .not_empty  (q_not_empty),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- rtl/dtx_checker.sv -----
// port-level checks for the tab expander, bound to the top level
module dtx_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   // tab, vertical tab and delete never pass through
   a_no_ctrl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata != dtx_pkg::CH_TAB && rsp_tdata != dtx_pkg::CH_VT &&
                     rsp_tdata != dtx_pkg::CH_DEL)
      else $error("unexpanded control character on output");

   // reset empties the output register
   a_reset_out: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // reset leaves the queue with room for a request
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("request not ready after reset");

endmodule

bind detab_tab_expander_core dtx_checker u_checker (.*);

// ----- test/testbench.sv -----
// testbench for the tab expander core: scoreboard-checked random and directed character streams
`timescale 1ns / 100ps

module testbench;

   localparam int MAX_COL     = 63;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_WAIT  = 20;
   localparam int IDLE_WAIT   = 8;

   // one emitted character and its end-of-request flag
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } out_char_type;

   // expands requests into expected characters and checks what the block emits
   class detab_scoreboard;
      out_char_type expected_chars[$];
      logic [5:0]   stop_gap;
      logic [5:0]   countdown;
      logic [5:0]   column;
      int           mismatches;

      function new();
         expected_chars.delete();
         stop_gap   = dtx_pkg::STOP_GAP_RESET;
         countdown  = dtx_pkg::STOP_GAP_RESET;
         column     = '0;
         mismatches = 0;
      endfunction

      function void set_stop_gap(logic [5:0] value);
         stop_gap = value;
      endfunction

      function void emit(logic [7:0] ch, logic last);
         out_char_type c;
         c.ch   = ch;
         c.last = last;
         expected_chars.push_back(c);
      endfunction

      // work out every character one accepted request produces
      function void expand_request(logic [7:0] ch, logic eoi);
         logic [5:0] size;
         int         n_sp;
         int         sum;
         size = (stop_gap == 6'd0) ? 6'd1 : stop_gap;
         if (eoi) begin
            emit(dtx_pkg::CH_NL, 1'b1);
            column    = '0;
            countdown = size;
         end else if (ch == dtx_pkg::CH_TAB) begin
            n_sp = (countdown == 6'd0) ? int'(size) : int'(countdown);
            for (int i = 0; i < n_sp; i++) emit(dtx_pkg::CH_SP, i == n_sp - 1);
            sum       = int'(column) + n_sp;
            column    = (sum > MAX_COL) ? 6'(MAX_COL) : 6'(sum);
            countdown = size;
         end else if (ch == dtx_pkg::CH_NL) begin
            emit(dtx_pkg::CH_NL, 1'b1);
            column    = '0;
            countdown = size;
         end else if (ch == dtx_pkg::CH_VT) begin
            // new line, then re-indent to the current column
            emit(dtx_pkg::CH_NL, column == 6'd0);
            for (int i = 0; i < int'(column); i++)
               emit(dtx_pkg::CH_SP, i == int'(column) - 1);
            countdown = size;
         end else if (ch == dtx_pkg::CH_DEL) begin
            emit(dtx_pkg::CH_BS, 1'b0);
            emit(dtx_pkg::CH_SP, 1'b0);
            emit(dtx_pkg::CH_BS, 1'b1);
            if (column != 6'd0) column = column - 6'd1;
            if (countdown >= size) countdown = 6'd1;
            else countdown = countdown + 6'd1;
         end else begin
            emit(ch, 1'b1);
            if (int'(column) < MAX_COL) column = column + 6'd1;
            if (countdown <= 6'd1) countdown = size;
            else countdown = countdown - 6'd1;
         end
      endfunction

      // compare one emitted character with the oldest expectation
      function void check_result(logic [7:0] ch, logic last);
         out_char_type e;
         if (expected_chars.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: char %0d last %0d", ch, last);
            return;
         end
         e = expected_chars.pop_front();
         if (e.ch !== ch || e.last !== last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected char %0d last %0d, got char %0d last %0d",
                        e.ch, e.last, ch, last);
         end
      endfunction
   endclass

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = '0;
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;
   logic       csr_we     = 1'b0;
   logic [5:0] csr_wdata  = '0;

   detab_scoreboard sb = new();
   bit  calm        = 1'b0;
   int  rsp_hold    = 0;
   int  cycle_count = 0;

   detab_tab_expander_core #(
      .MAX_COLUMN(MAX_COL)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // run guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // result side: check each accepted character, then drop rsp_tready for a random stall unless calm
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tdata, rsp_tlast);
         rsp_hold = calm ? 0 : $urandom_range(0, 6);
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // drive one request and wait for its acceptance
   task automatic send_request(logic [7:0] ch, logic eoi);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tlast  <= eoi;
      do @(posedge clock); while (!req_tready);
      sb.expand_request(ch, eoi);
   endtask

   // stop sending and wait until every expected character has come out
   task automatic drain;
      req_tvalid <= 1'b0;
      while (sb.expected_chars.size() != 0) @(posedge clock);
      repeat (IDLE_WAIT) @(posedge clock);
   endtask

   // tab size write, only while the block is idle
   task automatic write_stop_gap(logic [5:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.set_stop_gap(value);
   endtask

   // random request mix; nl_pct sets how often lines end, so low values reach the column limit
   task automatic random_phase(int count, int nl_pct);
      int         r;
      logic [7:0] ch;
      logic       eoi;
      for (int i = 0; i < count; i++) begin
         r   = $urandom_range(0, 99);
         eoi = 1'b0;
         ch  = $urandom_range(0, 255);
         if (r < 12) ch = dtx_pkg::CH_TAB;
         else if (r < 18) ch = dtx_pkg::CH_VT;
         else if (r < 27) ch = dtx_pkg::CH_DEL;
         else if (r < 27 + nl_pct) ch = dtx_pkg::CH_NL;
         else if (r < 29 + nl_pct) eoi = 1'b1;
         else if (r < 70) ch = $urandom_range(32, 126);
         send_request(ch, eoi);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: deletes at column zero, tabs, line breaks, re-indent, byte extremes, end of input
      calm = 1'b1;
      send_request(dtx_pkg::CH_DEL, 1'b0);
      send_request(dtx_pkg::CH_TAB, 1'b0);
      send_request(8'h41, 1'b0);
      send_request(dtx_pkg::CH_TAB, 1'b0);
      send_request(dtx_pkg::CH_VT, 1'b0);
      send_request(dtx_pkg::CH_NL, 1'b0);
      send_request(dtx_pkg::CH_VT, 1'b0);
      send_request(8'h00, 1'b0);
      send_request(8'hff, 1'b0);
      send_request(8'h61, 1'b0);
      send_request(dtx_pkg::CH_DEL, 1'b0);
      send_request(dtx_pkg::CH_DEL, 1'b0);
      send_request(dtx_pkg::CH_TAB, 1'b0);
      send_request(dtx_pkg::CH_VT, 1'b0);
      send_request(dtx_pkg::CH_BS, 1'b0);
      send_request(dtx_pkg::CH_SP, 1'b0);
      send_request(dtx_pkg::CH_TAB, 1'b1);
      send_request(dtx_pkg::CH_TAB, 1'b0);
      send_request(8'hff, 1'b1);
      calm = 1'b0;
      send_request(8'h7e, 1'b0);
      send_request(dtx_pkg::CH_TAB, 1'b0);
      send_request(dtx_pkg::CH_DEL, 1'b0);
      send_request(dtx_pkg::CH_VT, 1'b0);
      send_request(8'h00, 1'b1);

      // tab size extremes, zero, and mid-line size changes
      write_stop_gap(6'd63);
      random_phase(55, 2);
      write_stop_gap(6'd1);
      random_phase(55, 1);
      calm = 1'b1;
      write_stop_gap(6'd0);
      random_phase(60, 5);
      calm = 1'b0;
      write_stop_gap(6'd21);
      random_phase(55, 0);
      write_stop_gap(6'($urandom_range(1, 63)));
      random_phase(60, 8);
      write_stop_gap(6'd42);
      random_phase(55, 3);
      calm = 1'b1;
      write_stop_gap(6'd8);
      random_phase(60, 4);
      calm = 1'b0;
      write_stop_gap(6'd63);
      random_phase(60, 1);

      // wait out the tail
      req_tvalid <= 1'b0;
      while (sb.expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (sb.mismatches == 0 && sb.expected_chars.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
